// File: sv/ille_pkg.sv
// ----------------------------------------------------------------------------
// Linked-list engine package
// Widths, request and status codes and the structs shared by the list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ille_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 9;
  localparam int VAL_W    = 32;
  localparam int REQ_W    = 3;
  localparam int POS_W    = 9;
  localparam int ST_W     = 2;

  localparam logic [REQ_W-1:0] REQ_ADD_TAIL = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD_HEAD = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ADD_POS  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RM_TAIL  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RM_HEAD  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_RM_POS   = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } link_req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } value_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] removed;
    logic [ST_W-1:0]         status;
    logic [CNT_W-1:0]        length;
  } res_t;

endpackage

`default_nettype wire

// File: sv/ille_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ille_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/ille_ctrl.sv
// ----------------------------------------------------------------------------
// Linked-list engine sequencer
// Holds the list pointers and counts and steps each request through reads
// and writes of the value and link memories, walking one link per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ille_ctrl
  import ille_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    req_valid_i,
  output logic                         req_stall_o,
  input  wire logic [REQ_W-1:0]        req_type_i,
  input  wire logic signed [VAL_W-1:0] req_value_i,
  input  wire logic [POS_W-1:0]        req_pos_i,
  output link_req_t                    link_o,
  input  wire logic [IDX_W-1:0]        link_rdata_i,
  output value_req_t                   value_o,
  input  wire logic [VAL_W-1:0]        value_rdata_i,
  output logic                         res_valid_o,
  output res_t                         res_o,
  input  wire logic                    res_stall_i
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_ALLOC  = 4'd2;
  localparam logic [3:0] S_ADD    = 4'd3;
  localparam logic [3:0] S_TAIL   = 4'd4;
  localparam logic [3:0] S_PINS   = 4'd5;
  localparam logic [3:0] S_PINS2  = 4'd6;
  localparam logic [3:0] S_WALK   = 4'd7;
  localparam logic [3:0] S_RMHEAD = 4'd8;
  localparam logic [3:0] S_RMTAIL = 4'd9;
  localparam logic [3:0] S_RMMID  = 4'd10;
  localparam logic [3:0] S_RMVAL  = 4'd11;
  localparam logic [3:0] S_RMCAP  = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0]              state_q, state_d, ret_q, ret_d;
  logic [REQ_W-1:0]        req_q, req_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic [VAL_W-1:0]        val_q, val_d;
  logic [IDX_W-1:0]        first_q, first_d, last_q, last_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [IDX_W-1:0]        free_head_q, free_head_d;
  logic [CNT_W-1:0]        free_count_q, free_count_d;
  logic [CNT_W-1:0]        fresh_q, fresh_d;
  logic [CNT_W-1:0]        steps_q, steps_d;
  logic                    pend_q, pend_d;
  logic [IDX_W-1:0]        cur_q, cur_d, prev_q, prev_d, pprev_q, pprev_d;
  logic [IDX_W-1:0]        node_q, node_d, victim_q, victim_d;
  logic signed [VAL_W-1:0] rem_q, rem_d;
  logic [ST_W-1:0]         st_q, st_d;
  logic [IDX_W-1:0]        cur;
  logic                    room;
  logic                    pos_bad;

  assign cur     = pend_q ? link_rdata_i : cur_q;
  assign room    = (free_count_q != '0) || (fresh_q < CNT_W'(CAPACITY));
  assign pos_bad = (pos_q == '0) || (pos_q > count_q);

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    req_d        = req_q;
    pos_d        = pos_q;
    val_d        = val_q;
    first_d      = first_q;
    last_d       = last_q;
    count_d      = count_q;
    free_head_d  = free_head_q;
    free_count_d = free_count_q;
    fresh_d      = fresh_q;
    steps_d      = steps_q;
    pend_d       = pend_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    pprev_d      = pprev_q;
    node_d       = node_q;
    victim_d     = victim_q;
    rem_d        = rem_q;
    st_d         = st_q;
    link_o       = '0;
    value_o      = '0;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d   = req_type_i;
          val_d   = req_value_i;
          pos_d   = req_pos_i;
          rem_d   = '0;
          st_d    = ST_OK;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_DONE;
        if (req_q inside {REQ_ADD_TAIL, REQ_ADD_HEAD, REQ_ADD_POS}) begin
          if (!room) begin
            st_d = ST_FULL;
          end else if (count_q != '0 && req_q == REQ_ADD_POS && pos_bad) begin
            st_d = ST_RANGE;
          end else if (free_count_q != '0) begin
            node_d       = free_head_q;
            link_o.re    = 1'b1;
            link_o.raddr = free_head_q;
            state_d      = S_ALLOC;
          end else begin
            node_d  = fresh_q[IDX_W-1:0];
            fresh_d = fresh_q + CNT_W'(1);
            state_d = S_ADD;
          end
        end else if (req_q inside {REQ_RM_TAIL, REQ_RM_HEAD, REQ_RM_POS}) begin
          cur_d  = first_q;
          pend_d = 1'b0;
          if (count_q == '0) begin
            st_d = ST_EMPTY;
          end else if (count_q == CNT_W'(1)) begin
            victim_d = first_q;
            state_d  = S_RMVAL;
          end else if (req_q == REQ_RM_POS && pos_bad) begin
            st_d = ST_RANGE;
          end else if (req_q == REQ_RM_HEAD ||
                       (req_q == REQ_RM_POS && pos_q == POS_W'(1))) begin
            steps_d = CNT_W'(1);
            ret_d   = S_RMHEAD;
            state_d = S_WALK;
          end else if (req_q == REQ_RM_TAIL || pos_q == count_q) begin
            steps_d = count_q - CNT_W'(1);
            ret_d   = S_RMTAIL;
            state_d = S_WALK;
          end else begin
            steps_d = pos_q;
            ret_d   = S_RMMID;
            state_d = S_WALK;
          end
        end
      end
      S_ALLOC: begin
        free_head_d  = link_rdata_i;
        free_count_d = free_count_q - CNT_W'(1);
        state_d      = S_ADD;
      end
      S_ADD: begin
        value_o.we    = 1'b1;
        value_o.waddr = node_q;
        value_o.wdata = val_q;
        if (count_q == '0) begin
          link_o.we    = 1'b1;
          link_o.waddr = node_q;
          first_d      = node_q;
          last_d       = node_q;
          count_d      = CNT_W'(1);
          state_d      = S_DONE;
        end else if (req_q == REQ_ADD_TAIL) begin
          link_o.we    = 1'b1;
          link_o.waddr = node_q;
          state_d      = S_TAIL;
        end else if (req_q == REQ_ADD_HEAD || pos_q == POS_W'(1)) begin
          link_o.we    = 1'b1;
          link_o.waddr = node_q;
          link_o.wdata = first_q;
          first_d      = node_q;
          count_d      = count_q + CNT_W'(1);
          state_d      = S_DONE;
        end else begin
          cur_d   = first_q;
          pend_d  = 1'b0;
          steps_d = pos_q - CNT_W'(1);
          ret_d   = S_PINS;
          state_d = S_WALK;
        end
      end
      S_TAIL: begin
        link_o.we    = 1'b1;
        link_o.waddr = last_q;
        link_o.wdata = node_q;
        last_d       = node_q;
        count_d      = count_q + CNT_W'(1);
        state_d      = S_DONE;
      end
      S_PINS: begin
        link_o.we    = 1'b1;
        link_o.waddr = node_q;
        link_o.wdata = cur_q;
        state_d      = S_PINS2;
      end
      S_PINS2: begin
        link_o.we    = 1'b1;
        link_o.waddr = prev_q;
        link_o.wdata = node_q;
        count_d      = count_q + CNT_W'(1);
        state_d      = S_DONE;
      end
      S_WALK: begin
        cur_d = cur;
        if (steps_q == '0) begin
          pend_d  = 1'b0;
          state_d = ret_q;
        end else begin
          link_o.re    = 1'b1;
          link_o.raddr = cur;
          pprev_d      = prev_q;
          prev_d       = cur;
          pend_d       = 1'b1;
          steps_d      = steps_q - CNT_W'(1);
        end
      end
      S_RMHEAD: begin
        victim_d = prev_q;
        first_d  = cur_q;
        state_d  = S_RMVAL;
      end
      S_RMTAIL: begin
        link_o.we    = 1'b1;
        link_o.waddr = prev_q;
        last_d       = prev_q;
        victim_d     = cur_q;
        state_d      = S_RMVAL;
      end
      S_RMMID: begin
        link_o.we    = 1'b1;
        link_o.waddr = pprev_q;
        link_o.wdata = cur_q;
        victim_d     = prev_q;
        state_d      = S_RMVAL;
      end
      S_RMVAL: begin
        value_o.re    = 1'b1;
        value_o.raddr = victim_q;
        link_o.we     = 1'b1;
        link_o.waddr  = victim_q;
        link_o.wdata  = free_head_q;
        free_head_d   = victim_q;
        free_count_d  = free_count_q + CNT_W'(1);
        count_d       = count_q - CNT_W'(1);
        if (count_q == CNT_W'(1)) begin
          first_d = '0;
          last_d  = '0;
        end
        state_d = S_RMCAP;
      end
      S_RMCAP: begin
        rem_d   = value_rdata_i;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!res_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ret_q        <= S_IDLE;
      req_q        <= '0;
      pos_q        <= '0;
      first_q      <= '0;
      last_q       <= '0;
      count_q      <= '0;
      free_head_q  <= '0;
      free_count_q <= '0;
      fresh_q      <= '0;
      steps_q      <= '0;
      pend_q       <= 1'b0;
      st_q         <= ST_OK;
    end else begin
      state_q      <= state_d;
      ret_q        <= ret_d;
      req_q        <= req_d;
      pos_q        <= pos_d;
      first_q      <= first_d;
      last_q       <= last_d;
      count_q      <= count_d;
      free_head_q  <= free_head_d;
      free_count_q <= free_count_d;
      fresh_q      <= fresh_d;
      steps_q      <= steps_d;
      pend_q       <= pend_d;
      st_q         <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    pprev_q  <= pprev_d;
    node_q   <= node_d;
    victim_q <= victim_d;
    rem_q    <= rem_d;
  end

  assign req_stall_o    = (state_q != S_IDLE);
  assign res_valid_o    = (state_q == S_DONE);
  assign res_o.removed  = rem_q;
  assign res_o.status   = st_q;
  assign res_o.length   = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("list count exceeds the node pool");

  a_pool_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |->
      ({1'b0, count_q} + {1'b0, free_count_q} == {1'b0, fresh_q}))
    else $error("list and free nodes do not add up to nodes handed out");

  a_link_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(link_o.we && link_o.re))
    else $error("link memory read and written in the same cycle");

  a_walk_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && steps_q != '0) |=> pend_q)
    else $error("walk step did not leave a pending link read");

endmodule

`default_nettype wire

// File: sv/ille_outreg.sv
// ----------------------------------------------------------------------------
// Linked-list engine output register
// Holds one result until the receiver takes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module ille_outreg
  import ille_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                res_valid_i,
  input  wire res_t                res_i,
  output logic                     res_stall_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [VAL_W-1:0]  removed_value_o,
  output logic [ST_W-1:0]          status_o,
  output logic [CNT_W-1:0]         length_o
);

  logic valid_q, valid_d;
  res_t data_q;
  logic load;

  assign res_stall_o = valid_q && out_stall_i;
  assign load        = res_valid_i && !res_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o     = valid_q;
  assign removed_value_o = data_q.removed;
  assign status_o        = data_q.status;
  assign length_o        = data_q.length;

endmodule

`default_nettype wire

// File: sv/indexed_linked_list_engine_unit.sv
// ----------------------------------------------------------------------------
// Indexed linked-list engine
// Ordered list of signed 32-bit values kept in node memories with a free list.
//
// The input channel takes one request per transfer: a request type, a value
// for adds and a 1-based position for positional requests. in_stall_o is
// high while a request is being worked on. Every request answers with one
// result transfer on the output channel: the removed value, a status code
// and the list length after the request.
// Positional requests and tail removes walk the link memory from the head,
// one read per cycle, so their results take longer for entries further
// down the list; one request is worked on at a time. The result sits in an
// output register, so the next request is taken while the receiver stalls;
// a finished result waits in the sequencer until the register frees.
// Reset empties the list and the pool; the memories need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_linked_list_engine_unit
  import ille_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [REQ_W-1:0]        req_type_i,
  input  wire logic signed [VAL_W-1:0] item_value_i,
  input  wire logic [POS_W-1:0]        position_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [VAL_W-1:0]      removed_value_o,
  output logic [ST_W-1:0]              status_o,
  output logic [CNT_W-1:0]             length_o
);

  link_req_t        link_req;
  value_req_t       value_req;
  logic [IDX_W-1:0] link_rdata;
  logic [VAL_W-1:0] value_rdata;
  logic             res_valid;
  res_t             res;
  logic             res_stall;

  ille_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (in_valid_i),
    .req_stall_o   (in_stall_o),
    .req_type_i    (req_type_i),
    .req_value_i   (item_value_i),
    .req_pos_i     (position_i),
    .link_o        (link_req),
    .link_rdata_i  (link_rdata),
    .value_o       (value_req),
    .value_rdata_i (value_rdata),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_stall_i   (res_stall)
  );

  ille_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_req.we),
    .waddr_i (link_req.waddr),
    .wdata_i (link_req.wdata),
    .re_i    (link_req.re),
    .raddr_i (link_req.raddr),
    .rdata_o (link_rdata)
  );

  ille_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (value_req.we),
    .waddr_i (value_req.waddr),
    .wdata_i (value_req.wdata),
    .re_i    (value_req.re),
    .raddr_i (value_req.raddr),
    .rdata_o (value_rdata)
  );

  ille_outreg u_outreg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_valid_i     (res_valid),
    .res_i           (res),
    .res_stall_o     (res_stall),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .removed_value_o (removed_value_o),
    .status_o        (status_o),
    .length_o        (length_o)
  );

endmodule

`default_nettype wire

// File: tb/indexed_linked_list_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked-list engine testbench
// Drives list requests through the valid/stall input channel and predicts
// every result with a node-level model of the list, its free list and its
// fresh-node mark. A directed run covers the empty-list, one-entry, range
// and undefined-request cases. Random phases follow: a mix, a fill to a full
// pool followed by a mix, a drain to empty with recycled nodes, and a final
// mix. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module indexed_linked_list_engine_unit_tb;
  import ille_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD  = 300;
  localparam int END_WAIT   = 300;

  class list_scoreboard;
    logic [VAL_W-1:0] node_val [CAPACITY];
    logic [IDX_W-1:0] node_nxt [CAPACITY];
    logic [IDX_W-1:0] head_idx;
    logic [IDX_W-1:0] tail_idx;
    logic [IDX_W-1:0] free_top;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] free_cnt;
    logic [CNT_W-1:0] fresh_cnt;
    res_t             expected_q [$];
    int               errors;
    int               n_req;
    int               n_res;
    int               peak_len;
    int               status_hits [4];

    function new();
      head_idx  = '0;
      tail_idx  = '0;
      free_top  = '0;
      count     = '0;
      free_cnt  = '0;
      fresh_cnt = '0;
      errors    = 0;
      n_req     = 0;
      n_res     = 0;
      peak_len  = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function logic [IDX_W-1:0] take_node(logic [VAL_W-1:0] v);
      logic [IDX_W-1:0] n;
      if (free_cnt > 0) begin
        n = free_top;
        free_top = node_nxt[n];
        free_cnt--;
      end else begin
        n = fresh_cnt[IDX_W-1:0];
        fresh_cnt++;
      end
      node_val[n] = v;
      node_nxt[n] = '0;
      return n;
    endfunction

    function void give_node(logic [IDX_W-1:0] n);
      node_nxt[n] = free_top;
      free_top = n;
      free_cnt++;
    endfunction

    function logic [IDX_W-1:0] walk_to(int k);
      logic [IDX_W-1:0] n;
      n = head_idx;
      for (int i = 1; i < k; i++) n = node_nxt[n];
      return n;
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [VAL_W-1:0] val,
                               logic [POS_W-1:0] pos);
      res_t             r;
      logic [IDX_W-1:0] n;
      logic [IDX_W-1:0] prev;
      logic [IDX_W-1:0] victim;
      r.removed = '0;
      r.status  = ST_OK;
      if (req == REQ_ADD_TAIL || req == REQ_ADD_HEAD || req == REQ_ADD_POS) begin
        if (!(free_cnt > 0 || fresh_cnt < CAPACITY)) begin
          r.status = ST_FULL;
        end else if (count == 0) begin
          n = take_node(val);
          head_idx = n;
          tail_idx = n;
          count = 1;
        end else if (req == REQ_ADD_POS && (pos == 0 || pos > count)) begin
          r.status = ST_RANGE;
        end else begin
          n = take_node(val);
          if (req == REQ_ADD_TAIL) begin
            node_nxt[tail_idx] = n;
            tail_idx = n;
          end else if (req == REQ_ADD_HEAD || pos == 1) begin
            node_nxt[n] = head_idx;
            head_idx = n;
          end else begin
            prev = walk_to(int'(pos) - 1);
            node_nxt[n] = node_nxt[prev];
            node_nxt[prev] = n;
          end
          count++;
        end
      end else if (req == REQ_RM_TAIL || req == REQ_RM_HEAD || req == REQ_RM_POS) begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else if (count == 1) begin
          r.removed = node_val[head_idx];
          give_node(head_idx);
          head_idx = '0;
          tail_idx = '0;
          count = 0;
        end else if (req == REQ_RM_POS && (pos == 0 || pos > count)) begin
          r.status = ST_RANGE;
        end else begin
          if (req == REQ_RM_HEAD || (req == REQ_RM_POS && pos == 1)) begin
            victim = head_idx;
            head_idx = node_nxt[victim];
          end else if (req == REQ_RM_TAIL || pos == count) begin
            prev = walk_to(int'(count) - 1);
            victim = node_nxt[prev];
            node_nxt[prev] = '0;
            tail_idx = prev;
          end else begin
            prev = walk_to(int'(pos) - 1);
            victim = node_nxt[prev];
            node_nxt[prev] = node_nxt[victim];
          end
          r.removed = node_val[victim];
          give_node(victim);
          count--;
        end
      end
      r.length = count;
      n_req++;
      status_hits[r.status]++;
      if (int'(count) > peak_len) peak_len = int'(count);
      expected_q.push_back(r);
    endfunction

    function void check_result(logic signed [VAL_W-1:0] removed, logic [ST_W-1:0] status,
                               logic [CNT_W-1:0] length);
      res_t e;
      n_res++;
      if (expected_q.size() == 0) begin
        $error("Result transfer with no request outstanding");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (removed !== e.removed) begin
        $error("removed_value: expected %0d, actual %0d", e.removed, removed);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        errors++;
      end
      if (length !== e.length) begin
        $error("length: expected %0d, actual %0d", e.length, length);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [REQ_W-1:0]        req_type_i;
  logic signed [VAL_W-1:0] item_value_i;
  logic [POS_W-1:0]        position_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [VAL_W-1:0] removed_value_o;
  logic [ST_W-1:0]         status_o;
  logic [CNT_W-1:0]        length_o;

  list_scoreboard sb = new();
  int  idle_cycles = 0;
  int  tx_sent = 0;
  bit  tx_calm = 1'b0;

  indexed_linked_list_engine_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .item_value_i   (item_value_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .removed_value_o(removed_value_o),
    .status_o       (status_o),
    .length_o       (length_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(removed_value_o, status_o, length_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : receiver
    int wait_cycles;
    int taken;
    bit calm;
    taken = 0;
    calm = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (taken % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      wait_cycles = calm ? 0 : $urandom_range(0, 12);
      if (taken == 60) wait_cycles = LONG_HOLD;
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic post_request(logic [REQ_W-1:0] req, logic [VAL_W-1:0] val,
                              logic [POS_W-1:0] pos);
    int gap;
    if (tx_sent % 40 == 0) tx_calm = ($urandom_range(0, 2) == 0);
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    item_value_i <= val;
    position_i   <= pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(req, val, pos);
    tx_sent++;
    @(negedge clk_i);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [POS_W-1:0] pick_position(int len);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 8) return POS_W'($urandom_range(1, (len > 0) ? len : 1));
    if (sel == 8) return ($urandom_range(0, 1) == 0) ? '0 : POS_W'(len + 1);
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  function automatic logic [REQ_W-1:0] pick_add();
    case ($urandom_range(0, 2))
      0: return REQ_ADD_TAIL;
      1: return REQ_ADD_HEAD;
      default: return REQ_ADD_POS;
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] pick_remove();
    case ($urandom_range(0, 2))
      0: return REQ_RM_TAIL;
      1: return REQ_RM_HEAD;
      default: return REQ_RM_POS;
    endcase
  endfunction

  task automatic post_random(int add_pct);
    logic [REQ_W-1:0] req;
    if ($urandom_range(0, 29) == 0) begin
      req = ($urandom_range(0, 1) == 0) ? REQ_UNUSED_6 : REQ_UNUSED_7;
    end else if ($urandom_range(0, 99) < add_pct) begin
      req = pick_add();
    end else begin
      req = pick_remove();
    end
    post_request(req, $urandom, pick_position(int'(sb.count)));
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_type_i   = '0;
    item_value_i = '0;
    position_i   = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    post_request(REQ_RM_TAIL, 32'h0000_0001, 9'd0);
    post_request(REQ_RM_HEAD, 32'h0000_0002, 9'd1);
    post_request(REQ_RM_POS, 32'h0000_0003, 9'd3);
    post_request(REQ_ADD_POS, 32'h7FFF_FFFF, 9'd0);
    post_request(REQ_ADD_TAIL, 32'h8000_0000, 9'd0);
    post_request(REQ_ADD_HEAD, 32'hFFFF_FFFF, 9'd0);
    post_request(REQ_ADD_POS, 32'h1111_1111, 9'd0);
    post_request(REQ_ADD_POS, 32'h2222_2222, 9'd4);
    post_request(REQ_ADD_POS, 32'h0000_0000, 9'd3);
    post_request(REQ_ADD_POS, 32'h0000_3039, 9'd1);
    post_request(REQ_ADD_POS, 32'h3333_3333, 9'd511);
    post_request(REQ_RM_POS, 32'h0000_0000, 9'd0);
    post_request(REQ_RM_POS, 32'h0000_0000, 9'd256);
    post_request(REQ_RM_POS, 32'h0000_0000, 9'd5);
    post_request(REQ_RM_POS, 32'h0000_0000, 9'd1);
    post_request(REQ_RM_POS, 32'h0000_0000, 9'd2);
    post_request(REQ_UNUSED_6, 32'h1234_5678, 9'd0);
    post_request(REQ_UNUSED_7, 32'hFFFF_FFFF, 9'd511);
    post_request(REQ_RM_TAIL, 32'h0000_0000, 9'd0);
    post_request(REQ_RM_POS, 32'h0000_0000, 9'd9);
    post_request(REQ_ADD_HEAD, 32'h5555_5555, 9'd0);
    post_request(REQ_RM_TAIL, 32'h0000_0000, 9'd0);
    post_request(REQ_ADD_TAIL, 32'hAAAA_AAAA, 9'd0);
    post_request(REQ_RM_HEAD, 32'h0000_0000, 9'd0);
    hold_until_drained();

    repeat (40) post_random(60);

    while (sb.count < CAPACITY) begin
      post_request(pick_add(), $urandom, pick_position(int'(sb.count)));
    end
    repeat (12) post_request(pick_add(), $urandom, POS_W'($urandom_range(0, 511)));
    repeat (30) post_random(50);
    hold_until_drained();

    while (sb.count > 0) begin
      post_request(pick_remove(), $urandom, pick_position(int'(sb.count)));
    end
    repeat (4) post_request(pick_remove(), $urandom, POS_W'($urandom_range(0, 511)));

    repeat (30) post_random(55);

    hold_until_drained();
    repeat (END_WAIT) @(negedge clk_i);

    $display("Covered %0d requests: %0d ok, %0d out of range, %0d empty, %0d pool full.",
             sb.n_req, sb.status_hits[ST_OK], sb.status_hits[ST_RANGE],
             sb.status_hits[ST_EMPTY], sb.status_hits[ST_FULL]);
    $display("Checked %0d results, peak list length %0d, %0d mismatches.",
             sb.n_res, sb.peak_len, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
